### src/game_text_to_utf8_decoder_assert.svh
// assertion macros shared by the decoder rtl
// no dependencies; define ASSERT_OFF to compile them out
`ifndef GAME_TEXT_TO_UTF8_DECODER_ASSERT_SVH
`define GAME_TEXT_TO_UTF8_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define GTU_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`define GTU_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");
`else
`define GTU_NEVER(lbl, clk, rst_n, expr)
`define GTU_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

### src/gtu_pkg.sv
// shared types, constants and lookup functions of the font-to-utf8 decoder
// used by gtu_front, gtu_back and the top level
package gtu_pkg;

	localparam int TOK_DEPTH  = 16;
	localparam int INFO_DEPTH = 4;
	localparam int HOLD_N     = 6;

	localparam logic [7:0] B_STOP    = 8'hFF;
	localparam logic [7:0] B_ICON    = 8'h50;
	localparam logic [7:0] B_NEWLINE = 8'hFE;
	localparam logic [7:0] B_PARA    = 8'hFA;
	localparam logic [7:0] B_FC      = 8'hFC;

	localparam logic [7:0] CH_LB    = 8'h7B;
	localparam logic [7:0] CH_RB    = 8'h7D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [95:0] LOCK_STR = "{ICON:LOCK?}";
	localparam logic [95:0] PARA_STR = 96'("{PARABREAK}");
	localparam logic [95:0] FCQ_STR  = 96'("{FC?}");
	localparam logic [95:0] ICON_STR = 96'("{ICON:");

	localparam int N_CTL = 11;
	localparam logic [55:0] CTL_NAME [N_CTL] = '{
		"ICON0  ", "ICON1  ", "ICON2  ", "ICON3  ", "VIBRATE", "COLOR2 ",
		"XSPACE ", "YSPACE ", "SELPOS ", "NUM    ", "COLOR  "};
	localparam logic [2:0] CTL_LEN [N_CTL] = '{
		3'd5, 3'd5, 3'd5, 3'd5, 3'd7, 3'd6, 3'd6, 3'd6, 3'd6, 3'd3, 3'd5};

	typedef enum logic [2:0] {
		TK_CHAR, TK_NL, TK_PARA, TK_FCQ, TK_ICON, TK_CTL, TK_MARK
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [3:0]  op;
		logic [2:0]  cnt;
		logic [31:0] data;
	} tok_t;

	typedef struct packed {
		logic       done;
		logic [4:0] ntok;
	} info_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] idx;
		logic [2:0] cnt;
	} ctl_hit_t;

	function automatic ctl_hit_t ctl_lookup(input logic [7:0] b);
		ctl_hit_t r;
		r = '{hit: 1'b1, idx: 4'd0, cnt: 3'd1};
		case (b)
			8'hF0: r.idx = 4'd0;
			8'hF1: r.idx = 4'd1;
			8'hF2: r.idx = 4'd2;
			8'hF3: r.idx = 4'd3;
			8'hF5: begin r.idx = 4'd4; r.cnt = 3'd3; end
			8'hF6: begin r.idx = 4'd5; r.cnt = 3'd4; end
			8'hF7: r.idx = 4'd6;
			8'hF8: r.idx = 4'd7;
			8'hF9: begin r.idx = 4'd8; r.cnt = 3'd3; end
			8'hFB: begin r.idx = 4'd9; r.cnt = 3'd2; end
			8'hFD: begin r.idx = 4'd10; r.cnt = 3'd3; end
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
	endfunction

	// byte i of an n-character string literal held right-aligned
	function automatic logic [7:0] str_at(input logic [95:0] s, input int n,
			input logic [4:0] i);
		logic [95:0] sh;
		sh = s >> (8 * (n - 1 - int'(i)));
		return sh[7:0];
	endfunction

	// one-byte codes: {hit, ascii}
	function automatic logic [8:0] single_map(input logic [7:0] c);
		logic [8:0] r;
		r = 9'd0;
		case (c) inside
			8'h00, 8'h90:   r = {1'b1, CH_SPACE};
			[8'h01:8'h1A]:  r = {1'b1, c + 8'h40};
			[8'h1B:8'h34]:  r = {1'b1, c + 8'h46};
			[8'h35:8'h3E]:  r = {1'b1, c - 8'h05};
			[8'h3F:8'h48]:  r = {1'b1, c - 8'h0F};
			8'h8B:          r = {1'b1, 8'h27};
			8'h8E:          r = {1'b1, 8'h2D};
			8'h8F:          r = {1'b1, 8'h3F};
			8'h94:          r = {1'b1, 8'h3A};
			8'h95:          r = {1'b1, 8'h2C};
			8'h96:          r = {1'b1, 8'h2E};
			8'h97:          r = {1'b1, 8'h21};
			default:        r = 9'd0;
		endcase
		return r;
	endfunction

	// two-byte codes: {hit, first, second}
	function automatic logic [16:0] pair_map(input logic [7:0] c);
		logic [16:0] r;
		case (c)
			8'h52: r = {1'b1, 16'hC3A0};
			8'h54: r = {1'b1, 16'hC3A9};
			8'h55: r = {1'b1, 16'hC3AA};
			8'h56: r = {1'b1, 16'hC3AE};
			8'h5B: r = {1'b1, 16'hC39F};
			8'h60: r = {1'b1, 16'hC3A4};
			8'h63: r = {1'b1, 16'hC3BC};
			8'h64: r = {1'b1, 16'hC2A1};
			8'h65: r = {1'b1, 16'hC2BF};
			8'h66: r = {1'b1, 16'hC381};
			8'h67: r = {1'b1, 16'hC389};
			8'h68: r = {1'b1, 16'hC38D};
			8'h69: r = {1'b1, 16'hC391};
			8'h6A: r = {1'b1, 16'hC393};
			8'h6B: r = {1'b1, 16'hC39A};
			8'h6C: r = {1'b1, 16'hC3A1};
			8'h6D: r = {1'b1, 16'hC3A9};
			8'h6E: r = {1'b1, 16'hC3AD};
			8'h6F: r = {1'b1, 16'hC3B1};
			8'h70: r = {1'b1, 16'hC3B3};
			8'h71: r = {1'b1, 16'hC3BA};
			8'h81: r = {1'b1, 16'h6368};
			8'h83: r = {1'b1, 16'h7272};
			8'h9D: r = {1'b1, 16'hC3A2};
			8'hA4: r = {1'b1, 16'hC3B6};
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] char_len(input logic [7:0] c);
		logic [8:0]  s;
		logic [16:0] p;
		s = single_map(c);
		p = pair_map(c);
		if (s[8]) return 5'd1;
		if (p[16]) return 5'd2;
		if (c == B_ICON) return 5'd12;
		return 5'd4;
	endfunction

	function automatic logic [7:0] char_byte(input logic [7:0] c, input logic [4:0] i);
		logic [8:0]  s;
		logic [16:0] p;
		s = single_map(c);
		p = pair_map(c);
		if (s[8]) return s[7:0];
		if (p[16]) return (i == 5'd0) ? p[15:8] : p[7:0];
		if (c == B_ICON) return str_at(LOCK_STR, 12, i);
		case (i)
			5'd0:    return CH_LB;
			5'd1:    return hex_digit(c[7:4]);
			5'd2:    return hex_digit(c[3:0]);
			default: return CH_RB;
		endcase
	endfunction

	function automatic logic [4:0] tok_len(input tok_t t);
		case (t.kind)
			TK_CHAR: return char_len(t.data[7:0]);
			TK_NL:   return 5'd2;
			TK_PARA: return 5'd11;
			TK_FCQ:  return 5'd5;
			TK_ICON: return 5'd9;
			TK_CTL:  return 5'd2 + {2'd0, CTL_LEN[t.op]} + {2'd0, t.cnt} * 5'd3;
			default: return 5'd1;
		endcase
	endfunction

	function automatic logic [7:0] tok_byte(input tok_t t, input logic [4:0] pos);
		logic [4:0]  nl;
		logic [4:0]  j;
		logic [1:0]  g;
		logic [4:0]  r;
		logic [31:0] d;
		logic [55:0] nm;
		nl = {2'd0, CTL_LEN[t.op]};
		j  = pos - 5'd1 - nl;
		g  = (j >= 5'd9) ? 2'd3 : (j >= 5'd6) ? 2'd2 : (j >= 5'd3) ? 2'd1 : 2'd0;
		r  = j - {3'd0, g} * 5'd3;
		d  = t.data >> {g, 3'b000};
		nm = CTL_NAME[t.op] >> (8 * (7 - int'(pos)));
		case (t.kind)
			TK_CHAR: return char_byte(t.data[7:0], pos);
			TK_NL:   return (pos == 5'd0) ? CH_BSL : CH_N;
			TK_PARA: return str_at(PARA_STR, 11, pos);
			TK_FCQ:  return str_at(FCQ_STR, 5, pos);
			TK_ICON: begin
				if (pos < 5'd6) return str_at(ICON_STR, 6, pos);
				if (pos == 5'd6) return hex_digit(t.data[7:4]);
				if (pos == 5'd7) return hex_digit(t.data[3:0]);
				return CH_RB;
			end
			TK_CTL: begin
				if (pos == 5'd0) return CH_LB;
				if (pos <= nl) return nm[7:0];
				if (j < {2'd0, t.cnt} * 5'd3) begin
					if (r == 5'd0) return CH_COLON;
					if (r == 5'd1) return hex_digit(d[7:4]);
					return hex_digit(d[3:0]);
				end
				return CH_RB;
			end
			default: return 8'h00;
		endcase
	endfunction

endpackage

### src/gtu_queue.sv
// small first-in first-out queue between the decoder front and back
// depends on game_text_to_utf8_decoder_assert.svh
`include "game_text_to_utf8_decoder_assert.svh"

module gtu_queue #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW:0]      cnt_q;

	assign full  = cnt_q == (AW+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + AW'(1);
			if (pop) rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	`GTU_NEVER(a_push_full, clk, arst_n, push && full)
	`GTU_NEVER(a_pop_empty, clk, arst_n, pop && empty)

endmodule

### src/gtu_front.sv
// decoder front: takes source bytes, tracks icon headers, control codes
// and the unit count, and queues tokens; depends on gtu_pkg
module gtu_front #(
	parameter int MAX_UNITS = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	input  logic           tok_full,
	output logic           tok_push,
	output gtu_pkg::tok_t  tok,
	input  logic           info_full,
	output logic           info_push,
	output gtu_pkg::info_t info
);
	import gtu_pkg::*;

	localparam int CW = $clog2(MAX_UNITS + 1);
	localparam logic [CW-1:0] UMAX = CW'(MAX_UNITS);

	logic          stop_q, stop_n;
	logic [7:0]    hb_q [HOLD_N];
	logic [7:0]    hb_n [HOLD_N];
	logic [2:0]    hc_q, hc_n;
	logic [2:0]    pp_q, pp_n;
	logic          pend_q, pend_n;
	logic [3:0]    pidx_q, pidx_n;
	logic [CW-1:0] ucnt_q, ucnt_n;
	logic [7:0]    rq_q [HOLD_N];
	logic [7:0]    rq_n [HOLD_N];
	logic [2:0]    rqc_q, rqc_n;
	logic          busy_q, busy_n;
	logic          last_q, last_n;
	logic [4:0]    ntok_q, ntok_n;
	logic          step_ok;
	logic          acc;

	assign step_ok  = !tok_full && !info_full;
	assign in_ready = !busy_q && step_ok;
	assign acc      = in_valid && in_ready;

	always_comb begin
		logic [7:0]    b;
		logic          lst;
		logic          have;
		logic          rel;
		logic          ext;
		logic          udone;
		logic          do_stop;
		logic          more;
		logic          done;
		logic [4:0]    tot;
		logic [CW-1:0] u1;
		logic [7:0]    want;
		logic [2:0]    pqc;
		ctl_hit_t      ch;
		int            k;
		int            hcv;
		b       = acc ? in_byte : rq_q[0];
		lst     = acc ? in_last : last_q;
		have    = acc || (rqc_q != 3'd0);
		rel     = 1'b0;
		ext     = 1'b0;
		udone   = 1'b0;
		do_stop = 1'b0;
		more    = 1'b0;
		done    = 1'b0;
		tot     = 5'd0;
		u1      = ucnt_q;
		want    = (hc_q == 3'd3) ? 8'h01 : 8'h00;
		pqc     = rqc_q;
		ch      = ctl_lookup(b);
		hcv     = int'(hc_q);
		k       = 0;

		stop_n = stop_q;
		hb_n   = hb_q;
		hc_n   = hc_q;
		pp_n   = pp_q;
		pend_n = pend_q;
		pidx_n = pidx_q;
		ucnt_n = ucnt_q;
		rq_n   = rq_q;
		rqc_n  = rqc_q;
		busy_n = busy_q;
		last_n = last_q;
		ntok_n = ntok_q;
		tok_push  = 1'b0;
		tok       = '{kind: TK_CHAR, op: 4'd0, cnt: 3'd0, data: 32'd0};
		info_push = 1'b0;
		info      = '{done: 1'b0, ntok: 5'd0};

		if (acc && stop_q) begin
			// stopped: drop bytes, the buffer end rearms
			if (in_last) begin
				stop_n = 1'b0;
				hc_n   = 3'd0;
				pp_n   = 3'd0;
				pend_n = 1'b0;
				ucnt_n = '0;
				rqc_n  = 3'd0;
			end
		end else if (acc || (busy_q && step_ok)) begin
			// replayed bytes come off the front of the replay queue
			if (!acc && have) begin
				for (int i = 0; i < HOLD_N - 1; i++) rq_n[i] = rq_q[i+1];
				pqc = rqc_q - 3'd1;
			end
			rqc_n = pqc;

			if (have) begin
				if (pend_q) begin
					hb_n[hc_q] = b;
					if (pp_q <= 3'd1) begin
						tok_push  = 1'b1;
						tok.kind  = TK_CTL;
						tok.op    = pidx_q;
						tok.cnt   = hc_q + 3'd1;
						tok.data  = {hb_n[3], hb_n[2], hb_n[1], hb_n[0]};
						pend_n    = 1'b0;
						hc_n      = 3'd0;
						pp_n      = 3'd0;
						udone     = 1'b1;
					end else begin
						hc_n = hc_q + 3'd1;
						pp_n = pp_q - 3'd1;
					end
				end else if (hc_q != 3'd0) begin
					if (hc_q == 3'd2 || b == want) begin
						hb_n[hc_q] = b;
						if (hc_q == 3'd5) begin
							tok_push  = 1'b1;
							tok.kind  = TK_ICON;
							tok.data  = {24'd0, hb_q[2]};
							hc_n      = 3'd0;
							udone     = 1'b1;
						end else begin
							hc_n = hc_q + 3'd1;
						end
					end else begin
						rel = 1'b1;
						ext = 1'b1;
					end
				end else begin
					case (b)
						B_STOP: do_stop = 1'b1;
						B_ICON: begin
							hb_n[0] = b;
							hc_n    = 3'd1;
						end
						B_NEWLINE: begin
							tok_push = 1'b1;
							tok.kind = TK_NL;
							udone    = 1'b1;
						end
						B_PARA: begin
							tok_push = 1'b1;
							tok.kind = TK_PARA;
							udone    = 1'b1;
						end
						default: begin
							if (ch.hit) begin
								pend_n = 1'b1;
								pidx_n = ch.idx;
								pp_n   = ch.cnt;
								hc_n   = 3'd0;
							end else if (b == B_FC) begin
								tok_push = 1'b1;
								tok.kind = TK_FCQ;
								do_stop  = 1'b1;
							end else begin
								tok_push = 1'b1;
								tok.kind = TK_CHAR;
								tok.data = {24'd0, b};
								udone    = 1'b1;
							end
						end
					endcase
				end
			end else if (lst && !stop_q && !pend_q && hc_q != 3'd0) begin
				rel = 1'b1;
			end

			if (rel) begin
				// header abandoned: lock text, then held bytes go back in front
				k = hcv - 1 + int'(ext);
				for (int i = 0; i < HOLD_N; i++) begin
					if (i < hcv - 1) begin
						rq_n[i] = hb_q[3'(i + 1)];
					end else if (ext && i == hcv - 1) begin
						rq_n[i] = b;
					end else if (i - k >= 0 && i - k < HOLD_N - 1) begin
						rq_n[i] = (!acc && have) ? rq_q[3'(i - k + 1)] : rq_q[3'(i - k)];
					end
				end
				rqc_n    = pqc + 3'(k);
				hc_n     = 3'd0;
				tok_push = 1'b1;
				tok.kind = TK_CHAR;
				tok.data = {24'd0, B_ICON};
				udone    = 1'b1;
			end

			if (udone) begin
				u1     = (ucnt_q < UMAX) ? ucnt_q + CW'(1) : ucnt_q;
				ucnt_n = u1;
				if (u1 >= UMAX) do_stop = 1'b1;
			end

			if (do_stop) begin
				stop_n = 1'b1;
				hc_n   = 3'd0;
				pp_n   = 3'd0;
				pend_n = 1'b0;
				rqc_n  = 3'd0;
			end

			more = !stop_n && (rqc_n != 3'd0 || (lst && !pend_n && hc_n != 3'd0));
			if (more) begin
				busy_n = 1'b1;
				last_n = lst;
				ntok_n = ntok_q + 5'(tok_push);
			end else begin
				done = lst || stop_n;
				tot  = ntok_q + 5'(tok_push);
				if (done && tot == 5'd0) begin
					tok_push = 1'b1;
					tok.kind = TK_MARK;
					tot      = 5'd1;
				end
				info_push = tot != 5'd0;
				info      = '{done: done, ntok: tot};
				ntok_n    = 5'd0;
				busy_n    = 1'b0;
				if (lst) begin
					stop_n = 1'b0;
					hc_n   = 3'd0;
					pp_n   = 3'd0;
					pend_n = 1'b0;
					ucnt_n = '0;
					rqc_n  = 3'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		hb_q <= hb_n;
		rq_q <= rq_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= 1'b0;
			hc_q   <= 3'd0;
			pp_q   <= 3'd0;
			pend_q <= 1'b0;
			pidx_q <= 4'd0;
			ucnt_q <= '0;
			rqc_q  <= 3'd0;
			busy_q <= 1'b0;
			last_q <= 1'b0;
			ntok_q <= 5'd0;
		end else begin
			stop_q <= stop_n;
			hc_q   <= hc_n;
			pp_q   <= pp_n;
			pend_q <= pend_n;
			pidx_q <= pidx_n;
			ucnt_q <= ucnt_n;
			rqc_q  <= rqc_n;
			busy_q <= busy_n;
			last_q <= last_n;
			ntok_q <= ntok_n;
		end
	end

endmodule

### src/gtu_back.sv
// decoder back: expands queued tokens into utf-8 bytes, one word a cycle
// unless stalled; needs gtu_pkg and game_text_to_utf8_decoder_assert.svh
`include "game_text_to_utf8_decoder_assert.svh"

module gtu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tok_empty,
	input  gtu_pkg::tok_t  tok,
	output logic           tok_pop,
	input  logic           info_empty,
	input  gtu_pkg::info_t info,
	output logic           info_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_data,
	output logic           out_last,
	output logic [1:0]     out_user
);
	import gtu_pkg::*;

	logic [4:0] pos_q;
	logic [4:0] cnt_q;
	logic       ov_q;
	logic [7:0] od_q;
	logic       ol_q;
	logic [1:0] ou_q;
	logic [4:0] tlen;
	logic [7:0] tbyte;
	logic       go;
	logic       last_byte;
	logic       item_end;

	assign tlen      = tok_len(tok);
	assign tbyte     = tok_byte(tok, pos_q);
	assign go        = !tok_empty && !info_empty && (!ov_q || out_ready);
	assign last_byte = pos_q == tlen - 5'd1;
	assign item_end  = last_byte && (cnt_q == info.ntok - 5'd1);
	assign tok_pop   = go && last_byte;
	assign info_pop  = go && item_end;

	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign out_last  = ol_q;
	assign out_user  = ou_q;

	always_ff @(posedge clk) begin
		if (go) begin
			od_q <= (tok.kind == TK_MARK) ? 8'h00 : tbyte;
			ol_q <= item_end;
			ou_q <= {info.done, tok.kind != TK_MARK};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			pos_q <= 5'd0;
			cnt_q <= 5'd0;
		end else begin
			if (go) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (go) begin
				pos_q <= last_byte ? 5'd0 : pos_q + 5'd1;
				if (item_end) cnt_q <= 5'd0;
				else if (last_byte) cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	`GTU_IMPLY(a_pos_range, clk, arst_n, !tok_empty, pos_q < tlen)
	`GTU_IMPLY(a_cnt_range, clk, arst_n, !info_empty, cnt_q < info.ntok)

endmodule

### src/game_text_to_utf8_decoder.sv
// top level of the game font text to utf-8 decoder
// depends on gtu_pkg, gtu_front, gtu_queue and gtu_back

// One source byte is taken per word on the input stream, tlast marking the last byte
// of the buffer. The front decodes each input word as it is taken; after an icon header
// mismatch it also replays each held byte, holding off input meanwhile, and a header
// that a buffer end interrupts is released the same way. Results leave the back at
// one byte a cycle while the output is not stalled; a long expansion (control code,
// icon, lock text) of up to 20 bytes holds the back while the 16-entry token queue
// keeps taking input. An input item's bytes are sent only after its decoding has
// finished, since string_done on each byte depends on it. tuser carries byte_valid
// in bit 0 and string_done in bit 1; a word with byte_valid low is the bare end
// marker of a string that stopped without text. No clearing pass after reset.
module game_text_to_utf8_decoder #(
	parameter int MAX_UNITS = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] src_byte
	input  logic       s_axis_tlast,   // buffer_end
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] text_byte
	output logic       m_axis_tlast,   // run_last
	output logic [1:0] m_axis_tuser    // [0] byte_valid, [1] string_done
);
	import gtu_pkg::*;

	logic  tok_push, tok_full, tok_pop, tok_empty;
	tok_t  tok_w, tok_r;
	logic  info_push, info_full, info_pop, info_empty;
	info_t info_w, info_r;

	gtu_front #(.MAX_UNITS(MAX_UNITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.tok_full  (tok_full),
		.tok_push  (tok_push),
		.tok       (tok_w),
		.info_full (info_full),
		.info_push (info_push),
		.info      (info_w)
	);

	gtu_queue #(.WIDTH($bits(tok_t)), .DEPTH(TOK_DEPTH)) u_tok_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tok_push),
		.wdata  (tok_w),
		.full   (tok_full),
		.pop    (tok_pop),
		.rdata  (tok_r),
		.empty  (tok_empty)
	);

	gtu_queue #(.WIDTH($bits(info_t)), .DEPTH(INFO_DEPTH)) u_info_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (info_push),
		.wdata  (info_w),
		.full   (info_full),
		.pop    (info_pop),
		.rdata  (info_r),
		.empty  (info_empty)
	);

	gtu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_empty  (tok_empty),
		.tok        (tok_r),
		.tok_pop    (tok_pop),
		.info_empty (info_empty),
		.info       (info_r),
		.info_pop   (info_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_last   (m_axis_tlast),
		.out_user   (m_axis_tuser)
	);

endmodule

### tb/game_text_to_utf8_decoder_tb.sv
// testbench for game_text_to_utf8_decoder: drives encoded strings, predicts the utf-8 words
// with its own decoder model and checks every output word; depends on the rtl top level only
module game_text_to_utf8_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int UNIT_LIMIT = 4096;
	localparam int IDLE_LIMIT = 4000;

	localparam logic [7:0] SB_STOP    = 8'hFF;
	localparam logic [7:0] SB_ICON    = 8'h50;
	localparam logic [7:0] SB_NEWLINE = 8'hFE;
	localparam logic [7:0] SB_PARA    = 8'hFA;
	localparam logic [7:0] SB_FC      = 8'hFC;

	typedef struct {
		logic [7:0] text;
		logic       valid;
		logic       last;
		logic       done;
	} text_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic [1:0] m_axis_tuser;

	game_text_to_utf8_decoder #(.MAX_UNITS(UNIT_LIMIT)) dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// decoder state mirrored here
	logic       stopped;
	logic [7:0] held [6];
	int         held_n;
	int         params_left;
	logic [7:0] pend_op;
	int         units;

	logic [7:0] step_bytes [$];
	text_word_t text_q [$];
	int         err_count = 0;
	int         burst_left = 0;
	int         sent = 0;

	function automatic void clear_decoder();
		stopped = 1'b0;
		held_n = 0;
		params_left = 0;
		pend_op = 8'h00;
		units = 0;
	endfunction

	function automatic void put(logic [7:0] b);
		if (step_bytes.size() < 40)
			step_bytes.insert(step_bytes.size(), b);
	endfunction

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		return (n < 10) ? 8'h30 + n : 8'h37 + n;
	endfunction

	function automatic void put_hex(logic [7:0] v);
		put(hex_char(v[7:4]));
		put(hex_char(v[3:0]));
	endfunction

	function automatic void halt_string();
		stopped = 1'b1;
		held_n = 0;
		params_left = 0;
		pend_op = 8'h00;
	endfunction

	function automatic void count_unit();
		if (units < UNIT_LIMIT)
			units++;
		if (units >= UNIT_LIMIT)
			halt_string();
	endfunction

	function automatic int ctl_param_count(logic [7:0] op);
		case (op)
			8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF7, 8'hF8: return 1;
			8'hF5, 8'hF9, 8'hFD: return 3;
			8'hF6: return 4;
			8'hFB: return 2;
			default: return 0;
		endcase
	endfunction

	function automatic string ctl_label(logic [7:0] op);
		case (op)
			8'hF0: return "ICON0";
			8'hF1: return "ICON1";
			8'hF2: return "ICON2";
			8'hF3: return "ICON3";
			8'hF5: return "VIBRATE";
			8'hF6: return "COLOR2";
			8'hF7: return "XSPACE";
			8'hF8: return "YSPACE";
			8'hF9: return "SELPOS";
			8'hFB: return "NUM";
			default: return "COLOR";
		endcase
	endfunction

	function automatic void put_glyph(logic [7:0] c);
		logic [15:0] two;
		two = 16'h0000;
		if (c == 8'h00 || c == 8'h90) begin
			put(" ");
			return;
		end
		if (c >= 8'h01 && c <= 8'h1A) begin
			put(8'h41 + c - 8'h01);
			return;
		end
		if (c >= 8'h1B && c <= 8'h34) begin
			put(8'h61 + c - 8'h1B);
			return;
		end
		if (c >= 8'h35 && c <= 8'h3E) begin
			put(8'h30 + c - 8'h35);
			return;
		end
		if (c >= 8'h3F && c <= 8'h48) begin
			put(8'h30 + c - 8'h3F);
			return;
		end
		case (c)
			SB_ICON: begin put_str("{ICON:LOCK?}"); return; end
			8'h8B: begin put("'"); return; end
			8'h8E: begin put("-"); return; end
			8'h8F: begin put("?"); return; end
			8'h94: begin put(":"); return; end
			8'h95: begin put(","); return; end
			8'h96: begin put("."); return; end
			8'h97: begin put("!"); return; end
			8'h81: begin put_str("ch"); return; end
			8'h83: begin put_str("rr"); return; end
			8'h52: two = 16'hC3A0;
			8'h54: two = 16'hC3A9;
			8'h55: two = 16'hC3AA;
			8'h56: two = 16'hC3AE;
			8'h5B: two = 16'hC39F;
			8'h60: two = 16'hC3A4;
			8'h63: two = 16'hC3BC;
			8'h64: two = 16'hC2A1;
			8'h65: two = 16'hC2BF;
			8'h66: two = 16'hC381;
			8'h67: two = 16'hC389;
			8'h68: two = 16'hC38D;
			8'h69: two = 16'hC391;
			8'h6A: two = 16'hC393;
			8'h6B: two = 16'hC39A;
			8'h6C: two = 16'hC3A1;
			8'h6D: two = 16'hC3A9;
			8'h6E: two = 16'hC3AD;
			8'h6F: two = 16'hC3B1;
			8'h70: two = 16'hC3B3;
			8'h71: two = 16'hC3BA;
			8'h9D: two = 16'hC3A2;
			8'hA4: two = 16'hC3B6;
			default: ;
		endcase
		if (two != 16'h0000) begin
			put(two[15:8]);
			put(two[7:0]);
		end else begin
			put("{");
			put_hex(c);
			put("}");
		end
	endfunction

	// give up a partial icon header: lock text, then the held bytes decode again
	function automatic void drop_header(logic has_extra, logic [7:0] extra);
		logic [7:0] replay [$];
		for (int k = 1; k < held_n && k < 6; k++)
			replay.insert(replay.size(), held[k]);
		if (has_extra && replay.size() < 6)
			replay.insert(replay.size(), extra);
		held_n = 0;
		put_glyph(SB_ICON);
		count_unit();
		foreach (replay[k])
			decode_byte(replay[k]);
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		logic [7:0] hdr [6];
		int n;
		hdr = '{8'h50, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
		if (stopped)
			return;
		if (pend_op != 8'h00) begin
			if (held_n < 6)
				held[held_n++] = b;
			if (params_left > 0)
				params_left--;
			if (params_left == 0) begin
				put("{");
				put_str(ctl_label(pend_op));
				for (int p = 0; p < held_n; p++) begin
					put(":");
					put_hex(held[p]);
				end
				put("}");
				pend_op = 8'h00;
				held_n = 0;
				count_unit();
			end
			return;
		end
		if (held_n > 0) begin
			if (held_n < 6 && (held_n == 2 || b == hdr[held_n])) begin
				held[held_n++] = b;
				if (held_n == 6) begin
					put_str("{ICON:");
					put_hex(held[2]);
					put("}");
					held_n = 0;
					count_unit();
				end
			end else begin
				drop_header(1'b1, b);
			end
			return;
		end
		n = ctl_param_count(b);
		if (b == SB_STOP) begin
			halt_string();
		end else if (b == SB_ICON) begin
			held[0] = b;
			held_n = 1;
		end else if (b == SB_NEWLINE) begin
			put_str("\\n");
			count_unit();
		end else if (b == SB_PARA) begin
			put_str("{PARABREAK}");
			count_unit();
		end else if (n > 0) begin
			pend_op = b;
			params_left = n;
			held_n = 0;
		end else if (b == SB_FC) begin
			put_str("{FC?}");
			halt_string();
		end else begin
			put_glyph(b);
			count_unit();
		end
	endfunction

	function automatic void predict_words(logic [7:0] b, logic buf_end);
		logic done;
		if (stopped) begin
			if (buf_end)
				clear_decoder();
			return;
		end
		step_bytes.delete();
		decode_byte(b);
		if (buf_end) begin
			while (!stopped && pend_op == 8'h00 && held_n > 0)
				drop_header(1'b0, 8'h00);
			if (!stopped && pend_op != 8'h00)
				halt_string();
		end
		done = buf_end || stopped;
		if (done && step_bytes.size() == 0)
			text_q.insert(text_q.size(), '{8'h00, 1'b0, 1'b1, 1'b1});
		foreach (step_bytes[k])
			text_q.insert(text_q.size(),
				'{step_bytes[k], 1'b1, k == step_bytes.size() - 1, done});
		if (buf_end)
			clear_decoder();
	endfunction

	// one source word, sent in bursts with random gaps
	task automatic send_byte(logic [7:0] b, logic buf_end);
		if (burst_left == 0) begin
			int gap;
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 14);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= buf_end;
		do @(posedge clk); while (!s_axis_tready);
		predict_words(b, buf_end);
		sent++;
	endtask

	task automatic send_string(logic [7:0] bytes [$]);
		foreach (bytes[k])
			send_byte(bytes[k], k == bytes.size() - 1);
	endtask

	task automatic test_glyphs();
		send_string('{8'h00, 8'h01, 8'h1A, 8'h1B, 8'h34, 8'h35, 8'h3E, 8'h3F, 8'h48, 8'h90,
			8'h52, 8'hA4, 8'h81, 8'h97, 8'h49, 8'h80, SB_NEWLINE, SB_PARA});
	endtask

	task automatic test_icons();
		send_string('{SB_ICON, 8'h00, 8'hAB, 8'h01, 8'h00, 8'h00, 8'h05});
		// mismatch at offset 3, the held bytes decode again
		send_string('{SB_ICON, 8'h00, 8'h07, 8'h02, 8'h05});
		// header cut by the buffer end
		send_string('{8'h05, SB_ICON, 8'h00, SB_ICON});
	endtask

	task automatic test_controls();
		logic [7:0] ops [11];
		logic [7:0] s [$];
		ops = '{8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF5, 8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFB, 8'hFD};
		foreach (ops[k]) begin
			s.insert(s.size(), ops[k]);
			repeat (ctl_param_count(ops[k])) s.insert(s.size(), 8'($urandom_range(0, 255)));
		end
		s.insert(s.size(), 8'h02);
		send_string(s);
		// truncated control code
		send_string('{8'h03, 8'hF6, 8'h11, 8'hFF});
	endtask

	task automatic test_stops();
		send_string('{8'h04, SB_FC, 8'h05, 8'h06});
		send_string('{SB_STOP, 8'h07, SB_NEWLINE});
		send_string('{SB_STOP});
		send_string('{8'hF7});
	endtask

	task automatic test_random_strings();
		logic [7:0] s [$];
		logic [7:0] op;
		int kind;
		while (sent < 360) begin
			s.delete();
			repeat ($urandom_range(1, 12)) begin
				kind = $urandom_range(0, 99);
				if (kind < 45) begin
					s.insert(s.size(), 8'($urandom_range(0, 255)));
				end else if (kind < 60) begin
					s.insert(s.size(), 8'($urandom_range(0, 8'h48)));
				end else if (kind < 72) begin
					s = {s, SB_ICON, 8'h00, 8'($urandom_range(0, 255)), 8'h01, 8'h00, 8'h00};
					if ($urandom_range(0, 3) == 0)
						s[s.size() - $urandom_range(1, 5)] = 8'($urandom_range(0, 255));
				end else if (kind < 88) begin
					do op = 8'($urandom_range(8'hF0, 8'hFD)); while (ctl_param_count(op) == 0);
					s.insert(s.size(), op);
					repeat (ctl_param_count(op)) s.insert(s.size(), 8'($urandom_range(0, 255)));
				end else if (kind < 96) begin
					s.insert(s.size(), $urandom_range(0, 1) ? SB_NEWLINE : SB_PARA);
				end else begin
					s.insert(s.size(), $urandom_range(0, 1) ? SB_STOP : SB_FC);
				end
			end
			send_string(s);
		end
	endtask

	// receiver stall pattern: free-running, mostly stalled, or coin-flip stretches
	int ready_mode = 0;
	int mode_left = 0;
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(4, 40);
		end else begin
			mode_left--;
		end
		case (ready_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= $urandom_range(0, 1);
		endcase
	end

	always @(posedge clk) begin
		text_word_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (text_q.size() == 0) begin
				$error("unexpected word text_byte=%h", m_axis_tdata);
				err_count++;
			end else begin
				want = text_q.pop_front();
				if (m_axis_tdata !== want.text) begin
					$error("text_byte expected %h got %h", want.text, m_axis_tdata);
					err_count++;
				end
				if (m_axis_tuser[0] !== want.valid) begin
					$error("byte_valid expected %b got %b", want.valid, m_axis_tuser[0]);
					err_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("run_last expected %b got %b", want.last, m_axis_tlast);
					err_count++;
				end
				if (m_axis_tuser[1] !== want.done) begin
					$error("string_done expected %b got %b", want.done, m_axis_tuser[1]);
					err_count++;
				end
			end
		end
	end

	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("game_text_to_utf8_decoder_tb: done, errors");
			$finish;
		end
	end

	initial begin
		clear_decoder();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_glyphs();
		test_icons();
		test_controls();
		test_stops();
		test_random_strings();
		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;
		while (text_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("game_text_to_utf8_decoder_tb: done, clean");
		else
			$display("game_text_to_utf8_decoder_tb: done, errors");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/gtu_pkg.sv
src/gtu_queue.sv
src/gtu_front.sv
src/gtu_back.sv
src/game_text_to_utf8_decoder.sv
tb/game_text_to_utf8_decoder_tb.sv
